[rtl/swd_pkg.sv]
package swd_pkg;

    // Defaults of the store geometry.
    localparam int ROWS_DEF = 256;
    localparam int BINS_DEF = 256;

    // Field widths of the words on both channels.
    localparam int BIN_IDX_W = 8;
    localparam int MAG_W     = 20;
    localparam int PIX_W     = 10;
    localparam int COLOR_W   = 8;
    localparam int LEVEL_W   = 12;
    localparam int NUM_CH    = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int DIM_W      = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0]     DIM_RESET          = 11'd256;

    // Operation codes of an input word.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Level computation.
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 12'hFFF;
    localparam int                 LOG_STEPS = 16;
    // 0.4 * ln(2) / 16 scaled by 2^32.
    localparam logic [26:0]        LN2_SCALE = 27'd74426112;
    // floor(v / 5) equals (v * DIV5_RECIP) >> 18 for every v below 2^11.
    localparam logic [15:0]        DIV5_RECIP = 16'd52429;

    // Colormap endpoints in units of 1/20, one row per endpoint: red, green, blue.
    localparam logic [4:0] HEAT_PTS [5][3] = '{
        '{5'd0,  5'd0,  5'd3},
        '{5'd2,  5'd0,  5'd10},
        '{5'd14, 5'd2,  5'd10},
        '{5'd20, 5'd12, 5'd2},
        '{5'd20, 5'd20, 5'd18}
    };

    // Interpolated channel a*1024 + (b-a)*t, always within 0 to 20480.
    function automatic logic [14:0] heat_mix(input logic [1:0] seg, input logic [9:0] t,
                                             input logic [1:0] ch);
        logic signed [16:0] a;
        logic signed [16:0] b;
        logic signed [16:0] acc;
        a   = 17'(HEAT_PTS[3'(seg)][ch]);
        b   = 17'(HEAT_PTS[3'(seg) + 3'd1][ch]);
        acc = (a <<< 10) + (b - a) * $signed({7'b0, t});
        return acc[14:0];
    endfunction

endpackage

[rtl/swd_in_if.sv]
interface swd_in_if;
    import swd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [BIN_IDX_W-1:0] bin_index;
    logic [MAG_W-1:0]     magnitude;
    logic                 row_last;
    logic [PIX_W-1:0]     pixel_x;
    logic [PIX_W-1:0]     pixel_y;

    modport source (
        output valid, op, bin_index, magnitude, row_last, pixel_x, pixel_y,
        input  ready
    );
    modport sink (
        input  valid, op, bin_index, magnitude, row_last, pixel_x, pixel_y,
        output ready
    );
endinterface

[rtl/swd_out_if.sv]
interface swd_out_if;
    import swd_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (
        output valid, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue,
        output ready
    );
endinterface

[rtl/spectrogram_waterfall_display.sv]
// Push word: the next word is accepted only after the 16 squaring steps of the
// 31x31 multiplier, which a magnitude of 3840 or more skips as it saturates the level.
// Read word: the next word is accepted only after the bit-serial divider has run
// once for the row and once for the bin and the color is presented on the output.
// Reset: the control and configuration registers clear, then a clearing pass
// writes zero to all ROWS*BINS entries while no word is accepted.
module spectrogram_waterfall_display #(
    parameter int ROWS = swd_pkg::ROWS_DEF,
    parameter int BINS = swd_pkg::BINS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [swd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [swd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    swd_in_if.sink                          i_in,
    swd_out_if.source                       o_out
);
    import swd_pkg::*;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int BIN_W  = $clog2(BINS);
    localparam int DEPTH  = ROWS * BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PX2_W  = 2 * PIX_W;
    localparam int NUM_W  = PX2_W + BIN_W;
    localparam int DEN_W  = 2 * DIM_W;
    localparam int CNT_W  = $clog2(NUM_W);

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_NORM    = 13'b0000000000100,
        S_LOG     = 13'b0000000001000,
        S_SCALE   = 13'b0000000010000,
        S_WRITE   = 13'b0000000100000,
        S_MUL     = 13'b0000001000000,
        S_DIV_ROW = 13'b0000010000000,
        S_DIV_BIN = 13'b0000100000000,
        S_ADDR    = 13'b0001000000000,
        S_RDATA   = 13'b0010000000000,
        S_CMAP    = 13'b0100000000000,
        S_OUT     = 13'b1000000000000
    } t_state;

    t_state r_state;

    // Control state.
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ROW_W-1:0]  r_newest;
    logic [DIM_W-1:0]  r_disp_w;
    logic [DIM_W-1:0]  r_disp_h;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;

    // Push datapath.
    logic [BIN_IDX_W-1:0] r_push_bin;
    logic                 r_push_last;
    logic [MAG_W:0]       r_x;
    logic [1:0]           r_exp;
    logic [30:0]          r_y;
    logic [LOG_STEPS-1:0] r_frac;
    logic [44:0]          r_prod;

    // Read datapath.
    logic [PIX_W-1:0]  r_px;
    logic [PIX_W-1:0]  r_py;
    logic [PX2_W-1:0]  r_px2;
    logic [DEN_W-1:0]  r_dw2;
    logic [NUM_W-1:0]  r_bnum;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [ROW_W-1:0]  r_rd_row;
    logic [BIN_W-1:0]  r_rd_bin;
    logic [ROW_W-1:0]  r_ring;
    logic [14:0]       r_s [NUM_CH];
    logic [10:0]       r_v [NUM_CH];
    logic [COLOR_W-1:0] r_rgb [NUM_CH];

    // Combinational helpers.
    logic [DIM_W-1:0]   dw;
    logic [DIM_W-1:0]   dh;
    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     diff;
    logic               ge;
    logic [DEN_W-1:0]   n_rem;
    logic [NUM_W-1:0]   n_num;
    logic [61:0]        sq;
    logic [31:0]        sq_hi;
    logic [ROW_W:0]     ring_sum;
    logic [ROW_W-1:0]   ring;
    logic [LEVEL_W-1:0] level;
    logic               push_ok;
    logic               out_free;
    logic               div_last;
    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_addr;
    logic [LEVEL_W-1:0] ram_wdata;
    logic [LEVEL_W-1:0] ram_rdata;

    assign dw = (r_disp_w > DIM_W'(1)) ? r_disp_w - DIM_W'(1) : DIM_W'(1);
    assign dh = (r_disp_h > DIM_W'(1)) ? r_disp_h - DIM_W'(1) : DIM_W'(1);

    // One restoring division step per cycle; the quotient shifts into r_num.
    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        n_num = {r_num[NUM_W-2:0], ge};
    end

    assign div_last = r_cnt == CNT_W'(NUM_W - 1);

    // One squaring step of the log mantissa per cycle.
    assign sq    = 62'(r_y) * 62'(r_y);
    assign sq_hi = sq[61:30];

    assign ring_sum = {1'b0, r_newest} + {1'b0, r_rd_row};
    assign ring     = (ring_sum >= (ROW_W + 1)'(ROWS))
                    ? ring_sum[ROW_W-1:0] - ROW_W'(ROWS) : ring_sum[ROW_W-1:0];

    assign level   = (r_prod[44:32] > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : r_prod[43:32];
    assign push_ok = 32'(r_push_bin) < BINS;

    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_wdata = level;
        ram_addr  = ADDR_W'(r_newest) * ADDR_W'(BINS) + ADDR_W'(r_push_bin);
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                ram_addr  = r_clr_addr;
            end
            S_WRITE: begin
                ram_we = push_ok;
            end
            S_ADDR: begin
                ram_re   = 1'b1;
                ram_addr = ADDR_W'(r_ring) * ADDR_W'(BINS) + ADDR_W'(r_rd_bin);
            end
            default: begin
            end
        endcase
    end

    swd_ram #(
        .WIDTH(LEVEL_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (ram_re),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_w <= DIM_RESET;
            r_disp_h <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DISPLAY_WIDTH:  r_disp_w <= i_cfg_data;
                CFG_DISPLAY_HEIGHT: r_disp_h <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_newest    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output state handles its own valid flag.
            if (r_out_valid && o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= (i_in.op == OP_READ) ? S_MUL : S_NORM;
                    end
                end
                S_NORM: begin
                    r_cnt   <= '0;
                    r_state <= (|r_x[MAG_W:12]) ? S_WRITE : S_LOG;
                end
                S_LOG: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(LOG_STEPS - 1)) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (r_push_last) begin
                        r_newest <= (r_newest == ROW_W'(ROWS - 1))
                                  ? '0 : r_newest + ROW_W'(1);
                    end
                    r_state <= S_IDLE;
                end
                S_MUL: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV_ROW;
                end
                S_DIV_ROW: begin
                    r_cnt <= div_last ? '0 : r_cnt + CNT_W'(1);
                    if (div_last) begin
                        r_state <= S_DIV_BIN;
                    end
                end
                S_DIV_BIN: begin
                    r_cnt <= div_last ? '0 : r_cnt + CNT_W'(1);
                    if (div_last) begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_state <= S_RDATA;
                end
                S_RDATA: begin
                    r_state <= S_CMAP;
                end
                S_CMAP: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_push_bin  <= i_in.bin_index;
                r_push_last <= i_in.row_last;
                r_x         <= (MAG_W + 1)'(i_in.magnitude) + (MAG_W + 1)'(256);
                r_px        <= i_in.pixel_x;
                r_py        <= i_in.pixel_y;
            end
            S_NORM: begin
                r_frac <= '0;
                // A saturated magnitude skips the log; all ones clamps to the maximum.
                r_prod <= '1;
                if (r_x[11]) begin
                    r_exp <= 2'd3;
                    r_y   <= {r_x[11:0], 19'b0};
                end else if (r_x[10]) begin
                    r_exp <= 2'd2;
                    r_y   <= {r_x[10:0], 20'b0};
                end else if (r_x[9]) begin
                    r_exp <= 2'd1;
                    r_y   <= {r_x[9:0], 21'b0};
                end else begin
                    r_exp <= 2'd0;
                    r_y   <= {r_x[8:0], 22'b0};
                end
            end
            S_LOG: begin
                r_frac <= {r_frac[LOG_STEPS-2:0], sq_hi[31]};
                r_y    <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
            end
            S_SCALE: begin
                r_prod <= 45'({r_exp, r_frac}) * 45'(LN2_SCALE);
            end
            S_MUL: begin
                r_px2 <= PX2_W'(r_px) * PX2_W'(r_px);
                r_dw2 <= DEN_W'(dw) * DEN_W'(dw);
                r_num <= NUM_W'(r_py) * NUM_W'(ROWS - 1);
                r_den <= DEN_W'(dh);
                r_rem <= '0;
            end
            S_DIV_ROW: begin
                r_bnum <= NUM_W'(r_px2) * NUM_W'(BINS - 1);
                if (div_last) begin
                    r_rd_row <= (n_num > NUM_W'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                                                           : n_num[ROW_W-1:0];
                    r_num    <= r_bnum;
                    r_den    <= r_dw2;
                    r_rem    <= '0;
                end else begin
                    r_num <= n_num;
                    r_rem <= n_rem;
                end
            end
            S_DIV_BIN: begin
                r_num <= n_num;
                r_rem <= n_rem;
                if (div_last) begin
                    r_rd_bin <= (n_num > NUM_W'(BINS - 1)) ? BIN_W'(BINS - 1)
                                                           : n_num[BIN_W-1:0];
                    r_ring   <= ring;
                end
            end
            S_RDATA: begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_s[c] <= heat_mix(ram_rdata[11:10], ram_rdata[9:0], 2'(c));
                end
            end
            S_CMAP: begin
                // Scale by 255, add the rounding half and drop the 4096 part of 20480.
                for (int c = 0; c < NUM_CH; c++) begin
                    r_v[c] <= 11'(((23'(r_s[c]) << 8) - 23'(r_s[c]) + 23'd10240) >> 12);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    for (int c = 0; c < NUM_CH; c++) begin
                        r_rgb[c] <= 8'((27'(r_v[c]) * 27'(DIV5_RECIP)) >> 18);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready  = r_state == S_IDLE;
    assign o_out.valid = r_out_valid;
    assign o_out.red   = r_rgb[0];
    assign o_out.green = r_rgb[1];
    assign o_out.blue  = r_rgb[2];
endmodule

[rtl/swd_ram.sv]
module swd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[tb/spectrogram_waterfall_display_tb.sv]
module spectrogram_waterfall_display_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swd_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int N_ROWS        = ROWS_DEF;
    localparam int N_BINS        = BINS_DEF;
    localparam int SETTLE_CYCLES = 70;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RECENT_DEPTH  = 64;
    localparam int PHASE_WORDS   = 250;
    localparam int LEVEL_TOP     = 4095;
    // 0.4 * ln(2) / 16 in units of 2^-32.
    localparam longint unsigned LOG_SCALE = 64'd74426112;

    // Heat colormap knots in units of 1/20: red, green, blue.
    localparam int HEAT_KNOTS [5][3] = '{
        '{0, 0, 3}, '{2, 0, 10}, '{14, 2, 10}, '{20, 12, 2}, '{20, 20, 18}
    };

    typedef struct packed {
        logic                 op;
        logic [BIN_IDX_W-1:0] bin_index;
        logic [MAG_W-1:0]     magnitude;
        logic                 row_last;
        logic [PIX_W-1:0]     pixel_x;
        logic [PIX_W-1:0]     pixel_y;
    } word_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } color_t;

    typedef struct {
        int unsigned row_idx;
        int unsigned bin_idx;
    } entry_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    swd_in_if  in_ch ();
    swd_out_if out_ch ();

    spectrogram_waterfall_display #(
        .ROWS (N_ROWS),
        .BINS (N_BINS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Predictor state.
    logic [LEVEL_W-1:0] level_mem [N_ROWS*N_BINS];
    int unsigned        newest_row = 0;
    int unsigned        disp_w     = 256;
    int unsigned        disp_h     = 256;
    color_t             color_q [$];
    entry_t             recent_q [$];

    int  errors     = 0;
    int  cycles     = 0;
    int  stall_left = 0;
    bit  gaps_on    = 1'b0;
    bit  stalls_on  = 1'b0;

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("spectrogram_waterfall_display regression: fail");
            $finish;
        end
    end

    // Receiver back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    function automatic logic [LEVEL_W-1:0] level_of_mag(logic [MAG_W-1:0] mag);
        logic [31:0]       x;
        int                p;
        int                e;
        logic [63:0]       y;
        logic [15:0]       frac;
        longint unsigned   l;
        x = 32'd256 + 32'(mag);
        p = 0;
        while (p < 31 && (x >> (p + 1)) != 0)
            p++;
        e = p - 8;
        if (e >= 4)
            return LEVEL_W'(LEVEL_TOP);
        y = 64'(x) << (30 - p);
        frac = '0;
        // Each squaring doubles the exponent; an overflow past 2.0 yields one bit.
        for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30)) begin
                frac[0] = 1'b1;
                y = y >> 1;
            end
        end
        l = (64'(e) << 16) + 64'(frac);
        l = (l * LOG_SCALE) >> 32;
        return (l > LEVEL_TOP) ? LEVEL_W'(LEVEL_TOP) : LEVEL_W'(l);
    endfunction

    function automatic logic [COLOR_W-1:0] heat_channel(logic [LEVEL_W-1:0] lvl, int ch);
        int     seg;
        int     t;
        longint a;
        longint b;
        longint n;
        seg = int'(lvl >> 10);
        t   = int'(lvl & 12'h3FF);
        a   = HEAT_KNOTS[seg][ch];
        b   = HEAT_KNOTS[seg + 1][ch];
        n   = 255 * (a * 1024 + (b - a) * t);
        return COLOR_W'((n + 10240) / 20480);
    endfunction

    function automatic int unsigned row_of_pixel(int unsigned py);
        longint unsigned dh;
        longint unsigned r;
        dh = (disp_h > 1) ? disp_h - 1 : 1;
        r  = 64'(py) * 64'(N_ROWS - 1) / dh;
        return (r > N_ROWS - 1) ? N_ROWS - 1 : int'(r);
    endfunction

    function automatic int unsigned bin_of_pixel(int unsigned px);
        longint unsigned dw;
        longint unsigned b;
        dw = (disp_w > 1) ? disp_w - 1 : 1;
        b  = 64'(px) * 64'(px) * 64'(N_BINS - 1) / (dw * dw);
        return (b > N_BINS - 1) ? N_BINS - 1 : int'(b);
    endfunction

    // Finds a pixel coordinate that lands on the target row or bin, starting the
    // search at a random place so that different pixels get used.
    function automatic int pixel_for(bit along_y, int unsigned target);
        int unsigned start;
        int unsigned p;
        start = $urandom_range(0, 1023);
        for (int k = 0; k < 1024; k++) begin
            p = (start + k) % 1024;
            if ((along_y ? row_of_pixel(p) : bin_of_pixel(p)) == target)
                return p;
        end
        return -1;
    endfunction

    function automatic word_t random_word(logic op);
        word_t w;
        w.op        = op;
        w.bin_index = BIN_IDX_W'($urandom);
        w.magnitude = MAG_W'($urandom);
        w.row_last  = 1'($urandom);
        w.pixel_x   = PIX_W'($urandom);
        w.pixel_y   = PIX_W'($urandom);
        return w;
    endfunction

    // Read word aimed at one entry of the ring, falling back to a random pixel
    // where the current screen size cannot reach it.
    function automatic word_t read_at(int unsigned ring_row, int unsigned bin);
        word_t w;
        int    px;
        int    py;
        w  = random_word(OP_READ);
        py = pixel_for(1'b1, (ring_row + N_ROWS - newest_row) % N_ROWS);
        px = pixel_for(1'b0, bin);
        if (py >= 0)
            w.pixel_y = PIX_W'(py);
        if (px >= 0)
            w.pixel_x = PIX_W'(px);
        return w;
    endfunction

    function automatic word_t random_item();
        word_t  w;
        entry_t e;
        if ($urandom_range(0, 99) < 45) begin
            w = random_word(OP_PUSH);
            // Spread magnitudes over the whole log range.
            w.magnitude = MAG_W'($urandom & ((32'd1 << $urandom_range(0, 20)) - 1));
            w.row_last  = ($urandom_range(0, 3) == 0);
        end else if (recent_q.size() != 0 && $urandom_range(0, 9) < 6) begin
            e = recent_q[$urandom_range(0, recent_q.size() - 1)];
            w = read_at(e.row_idx, e.bin_idx);
        end else begin
            w = random_word(OP_READ);
        end
        return w;
    endfunction

    task automatic predict_waterfall(input word_t w);
        color_t             c;
        logic [LEVEL_W-1:0] lvl;
        entry_t             e;
        if (w.op == OP_PUSH) begin
            level_mem[newest_row * N_BINS + w.bin_index] = level_of_mag(w.magnitude);
            e.row_idx = newest_row;
            e.bin_idx = w.bin_index;
            recent_q.push_back(e);
            if (recent_q.size() > RECENT_DEPTH)
                void'(recent_q.pop_front());
            if (w.row_last)
                newest_row = (newest_row + 1) % N_ROWS;
        end else begin
            lvl = level_mem[((newest_row + row_of_pixel(w.pixel_y)) % N_ROWS) * N_BINS
                            + bin_of_pixel(w.pixel_x)];
            c.red   = heat_channel(lvl, 0);
            c.green = heat_channel(lvl, 1);
            c.blue  = heat_channel(lvl, 2);
            color_q.push_back(c);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high.
    task automatic send_word(input word_t w);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= w.op;
        in_ch.bin_index <= w.bin_index;
        in_ch.magnitude <= w.magnitude;
        in_ch.row_last  <= w.row_last;
        in_ch.pixel_x   <= w.pixel_x;
        in_ch.pixel_y   <= w.pixel_y;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        predict_waterfall(w);
        @(negedge i_clk);
    endtask

    // A push leaves no result behind, so the block may still be busy after the
    // last color arrives.
    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (color_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_display(input int unsigned w, input int unsigned h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DISPLAY_WIDTH;
        i_cfg_data  <= CFG_DATA_W'(w);
        @(negedge i_clk);
        i_cfg_index <= CFG_DISPLAY_HEIGHT;
        i_cfg_data  <= CFG_DATA_W'(h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        disp_w = w & 11'h7FF;
        disp_h = h & 11'h7FF;
    endtask

    task automatic check_channel(input string name, input logic [COLOR_W-1:0] want,
                                 input logic [COLOR_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        color_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (color_q.size() == 0) begin
                $display("%0t: color %0d/%0d/%0d arrived with nothing expected",
                         $time, out_ch.red, out_ch.green, out_ch.blue);
                errors++;
            end else begin
                want = color_q.pop_front();
                check_channel("red", want.red, out_ch.red);
                check_channel("green", want.green, out_ch.green);
                check_channel("blue", want.blue, out_ch.blue);
            end
        end
    end

    // The store is cleared by reset, so every pixel reads the color of level zero.
    task automatic test_cleared_store();
        word_t w;
        w = random_word(OP_READ);
        w.pixel_x = '0;
        w.pixel_y = '0;
        send_word(w);
        w.pixel_x = '1;
        w.pixel_y = '1;
        send_word(w);
        w.pixel_x = PIX_W'(511);
        w.pixel_y = PIX_W'(300);
        send_word(w);
        settle_block();
    endtask

    // One row of pushes across all colormap segments and the saturating range,
    // then a read of each entry after the row has scrolled to the bottom line.
    task automatic test_level_extremes();
        word_t       w;
        int unsigned mags [8];
        int unsigned row0;
        mags = '{0, 1, 400, 1000, 2000, 3839, 3840, 1048575};
        row0 = newest_row;
        for (int k = 0; k < 8; k++) begin
            w = random_word(OP_PUSH);
            w.bin_index = BIN_IDX_W'(k);
            w.magnitude = MAG_W'(mags[k]);
            w.row_last  = (k == 7);
            send_word(w);
        end
        for (int k = 0; k < 8; k++)
            send_word(read_at(row0, k));
        settle_block();
    endtask

    // Degenerate and oversized screens: divisors below one and off-screen pixels.
    task automatic test_mapping_extremes();
        word_t w;
        set_display(0, 1);
        w = random_word(OP_READ);
        w.pixel_x = '0;
        w.pixel_y = '0;
        send_word(w);
        w.pixel_x = '1;
        w.pixel_y = '1;
        send_word(w);
        w.pixel_x = PIX_W'(1);
        w.pixel_y = PIX_W'(1);
        send_word(w);
        settle_block();
        set_display(2047, 2047);
        w.pixel_x = '1;
        w.pixel_y = '1;
        send_word(w);
        w.pixel_x = '0;
        send_word(w);
        settle_block();
    endtask

    task automatic test_random_traffic();
        int unsigned widths [8];
        int unsigned heights [8];
        widths  = '{256, 2, 1024, 0, 2047, 1, 2, 256};
        heights = '{256, 2, 1024, 1, 1023, 2047, 2, 256};
        widths[6]  = $urandom_range(2, 1024);
        heights[6] = $urandom_range(2, 1024);
        for (int ph = 0; ph < 8; ph++) begin
            set_display(widths[ph], heights[ph]);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // The last phase runs at full rate on both sides.
                if (n % 50 == 0) begin
                    gaps_on   = (ph != 7) && ($urandom_range(0, 2) != 0);
                    stalls_on = (ph != 7) && ($urandom_range(0, 2) != 0);
                end
                send_word(random_item());
            end
            settle_block();
        end
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.op        = OP_PUSH;
        in_ch.bin_index = '0;
        in_ch.magnitude = '0;
        in_ch.row_last  = 1'b0;
        in_ch.pixel_x   = '0;
        in_ch.pixel_y   = '0;
        out_ch.ready    = 1'b0;
        foreach (level_mem[i])
            level_mem[i] = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_cleared_store();
        test_level_extremes();
        test_mapping_extremes();
        test_random_traffic();
        settle_block();
        if (errors == 0) begin
            $display("spectrogram_waterfall_display regression: pass");
        end else begin
            $display("spectrogram_waterfall_display regression: fail");
        end
        $finish;
    end

endmodule
